>>> rtl/core/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> rtl/core/sortchk_pkg.sv
package sortchk_pkg;
  localparam int unsigned ElemW = 64;
  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_STRICT  = 2'd0,
    CFG_INCR    = 2'd1,
    CFG_MISSBIG = 2'd2,
    CFG_KIND    = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic strict_order;
    logic increasing_order;
    logic missing_is_largest;
    logic element_kind;
  } cfg_t;

  // Relation of previous element to current one
  typedef struct packed {
    logic lt;
    logic eq;
  } rel_t;
endpackage

>>> rtl/core/sortchk_compare.sv
module sortchk_compare import sortchk_pkg::*; (
  input  cfg_t             cfg_i,
  input  logic [ElemW-1:0] prev_i,
  input  logic             prev_miss_i,
  input  logic [ElemW-1:0] cur_i,
  output logic             cur_miss_o,
  output rel_t             rel_o
);
  logic        v_lt, v_eq;
  logic        pz, cz, pneg, cneg, mag_lt, mag_eq;
  logic signed [31:0] pi, ci;

  // Flag missing values per element kind
  always_comb begin
    if (cfg_i.element_kind) begin
      cur_miss_o = (&cur_i[62:52]) && (|cur_i[51:0]);
    end else begin
      cur_miss_o = (cur_i[31:0] == 32'h8000_0000);
    end
  end

  // Compare non-missing values
  always_comb begin
    pi = prev_i[31:0];
    ci = cur_i[31:0];
    pz = (prev_i[62:0] == '0);
    cz = (cur_i[62:0] == '0);
    pneg = prev_i[63];
    cneg = cur_i[63];
    mag_lt = prev_i[62:0] < cur_i[62:0];
    mag_eq = prev_i[62:0] == cur_i[62:0];
    if (cfg_i.element_kind) begin
      if (pz && cz) begin
        v_eq = 1'b1;
        v_lt = 1'b0;
      end else if (pneg != cneg) begin
        v_eq = 1'b0;
        v_lt = pneg;
      end else begin
        v_eq = mag_eq;
        v_lt = pneg ? (!mag_lt && !mag_eq) : mag_lt;
      end
    end else begin
      v_eq = (pi == ci);
      v_lt = (pi < ci);
    end
  end

  // Rank missing values above or below all others
  always_comb begin
    if (prev_miss_i && cur_miss_o) begin
      rel_o = '{lt: 1'b0, eq: 1'b1};
    end else if (prev_miss_i) begin
      rel_o = '{lt: !cfg_i.missing_is_largest, eq: 1'b0};
    end else if (cur_miss_o) begin
      rel_o = '{lt: cfg_i.missing_is_largest, eq: 1'b0};
    end else begin
      rel_o = '{lt: v_lt, eq: v_eq};
    end
  end
endmodule

>>> rtl/core/sortedness_checker_core.sv
// Streaming sortedness checker: elements arrive one per transfer, every
// cycle if offered, and one verdict leaves for each element marked last,
// in the cycle after it is taken. The throughput of one element per cycle is
// set by the single compare against the registered prior element; a
// waiting verdict sits in an output register, and while that verdict is
// stalled downstream the input is held as well, whether or not the next
// element is marked last.
`include "assert_macros.svh"
module sortedness_checker_core import sortchk_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic             cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [ElemW-1:0] element_bits_i,
  input  logic             is_last_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             is_sorted_o
);
  cfg_t             cfg_q;
  logic [ElemW-1:0] prior_q;
  logic             prior_miss_q, have_prior_q, sorted_q;
  logic             out_valid_q, is_sorted_q;
  logic             in_xfer, out_xfer, cur_miss, ok, verdict;
  rel_t             rel;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{strict_order: 1'b0, increasing_order: 1'b1,
                 missing_is_largest: 1'b1, element_kind: 1'b1};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_STRICT:  cfg_q.strict_order <= cfg_data_i;
        CFG_INCR:    cfg_q.increasing_order <= cfg_data_i;
        CFG_MISSBIG: cfg_q.missing_is_largest <= cfg_data_i;
        CFG_KIND:    cfg_q.element_kind <= cfg_data_i;
        default: ;
      endcase
    end
  end

  sortchk_compare u_cmp (
    .cfg_i       (cfg_q),
    .prev_i      (prior_q),
    .prev_miss_i (prior_miss_q),
    .cur_i       (element_bits_i),
    .cur_miss_o  (cur_miss),
    .rel_o       (rel)
  );

  // Check the pair against the configured order
  always_comb begin
    if (cfg_q.increasing_order) begin
      ok = rel.lt || (!cfg_q.strict_order && rel.eq);
    end else begin
      ok = !rel.lt && !(cfg_q.strict_order && rel.eq);
    end
  end

  assign verdict    = sorted_q && (!have_prior_q || ok);
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_xfer   = out_valid_q && !out_stall_i;

  // Advance vector state on each input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prior_miss_q <= 1'b0;
      have_prior_q <= 1'b0;
      sorted_q     <= 1'b1;
    end else if (in_xfer) begin
      prior_miss_q <= cur_miss && !is_last_i;
      have_prior_q <= !is_last_i;
      sorted_q     <= is_last_i || verdict;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      prior_q <= element_bits_i;
    end
  end

  // Hold the verdict until the downstream transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer && is_last_i) begin
      out_valid_q <= 1'b1;
    end else if (out_xfer) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && is_last_i) begin
      is_sorted_q <= verdict;
    end
  end

  assign out_valid_o = out_valid_q;
  assign is_sorted_o = is_sorted_q;

  `ASSERT_NEXT(a_last_clears, clk_i, rst_ni, in_xfer && is_last_i,
               !have_prior_q && sorted_q, "state not cleared after last element")
  `ASSERT_NEXT(a_last_gives_out, clk_i, rst_ni, in_xfer && is_last_i,
               out_valid_q, "no verdict after last element")
  `ASSERT_IMPL(a_fail_sticks, clk_i, rst_ni,
               (!sorted_q && !(in_xfer && is_last_i)) |=> !sorted_q,
               "running verdict recovered mid-vector")
  `ASSERT_NEXT(a_first_ok, clk_i, rst_ni, in_xfer && !have_prior_q && !is_last_i,
               sorted_q, "first element broke the verdict")
endmodule
